// ===== rtl/core/tlr_pkg.sv =====
package tlr_pkg;

    // largest number of tiles in one arrangement
    localparam int MAX_TILES = 64;

    localparam int COORD_W = 16;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int ROOT_W  = 4;
    localparam int LINE_W  = 3;
    localparam int DIV_CNT_W = $clog2(COORD_W);

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_TILES);

    // layout modes
    localparam logic [1:0] MODE_TALL = 2'd0;
    localparam logic [1:0] MODE_WIDE = 2'd1;
    localparam logic [1:0] MODE_GRID = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_VARIANT = 2'd1;
    localparam logic [1:0] CFG_RATIO   = 2'd2;

    localparam logic [COORD_W-1:0] RATIO_RST = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_CELL,
        ST_DIV_LINES,
        ST_DIV_MINOR,
        ST_DIV_FULL,
        ST_DIV_LAST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic               variant;
        logic [COORD_W-1:0] ratio;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COORD_W-1:0] quot;
        logic [COUNT_W-1:0] rem;
    } t_div_rsp;

    // smallest p with p * p >= n, for n up to MAX_TILES
    function automatic logic [ROOT_W-1:0] f_ceil_root(input logic [COUNT_W-1:0] n);
        logic [ROOT_W-1:0] p;
        p = ROOT_W'(8);
        for (int i = 7; i >= 1; i--) begin
            if (i * i >= int'(n)) begin
                p = ROOT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/tlr_div.sv =====
module tlr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlr_pkg::t_div_req i_req,
    output tlr_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [tlr_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [tlr_pkg::COORD_W-1:0]     r_quo;
    logic [tlr_pkg::COUNT_W-1:0]     r_rem;
    logic [tlr_pkg::COUNT_W-1:0]     r_dvs;

    logic [tlr_pkg::COUNT_W:0] w_trial;
    logic [tlr_pkg::COUNT_W:0] w_diff;
    logic                      w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[tlr_pkg::COORD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tlr_pkg::COORD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[tlr_pkg::COUNT_W-1:0] : w_trial[tlr_pkg::COUNT_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/core/tlr_ctrl.sv =====
module tlr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlr_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_x,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_y,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_width,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_height,
    input  logic [tlr_pkg::COUNT_W-1:0]   i_tile_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tlr_pkg::INDEX_W-1:0]   o_tile_index,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_x,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_y,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_width,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_height,
    output logic                          o_last_tile,
    output tlr_pkg::t_div_req             o_div_req,
    input  tlr_pkg::t_div_rsp             i_div_rsp
);

    localparam int CW = tlr_pkg::COORD_W;
    localparam int NW = tlr_pkg::COUNT_W;
    localparam int RW = tlr_pkg::ROOT_W;
    localparam int LW = tlr_pkg::LINE_W;

    tlr_pkg::t_state r_state, n_state;
    logic r_div_wait, n_div_wait;

    // captured item and derived sizes
    logic [CW-1:0] r_ax, r_ay, r_aw, r_ah;
    logic [NW-1:0] r_n;
    logic [CW-1:0] r_msize, n_msize;
    logic [CW-1:0] r_cell, n_cell;
    logic [RW-1:0] r_line_cells;
    logic [RW-1:0] r_lines, n_lines;
    logic [RW-1:0] r_last_cnt, n_last_cnt;
    logic [CW-1:0] r_line_pitch, n_line_pitch;
    logic [CW-1:0] r_cmaj_last, n_cmaj_last;

    // walk counters
    logic [NW-1:0] r_k, n_k;
    logic [CW-1:0] r_off, n_off;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_line, n_line;
    logic [CW-1:0] r_maj_off, n_maj_off;
    logic [CW-1:0] r_min_off, n_min_off;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [tlr_pkg::INDEX_W-1:0] r_o_k;
    logic [CW-1:0] r_o_x, r_o_y, r_o_w, r_o_h;
    logic          r_o_last;
    logic [CW-1:0] w_x, w_y, w_w, w_h;

    logic          w_accept, w_load, w_last, w_wide, w_col, w_grid;
    logic [NW-1:0] w_n_sat;
    logic [CW-1:0] w_total, w_span, w_base_main, w_base_cross, w_ssize, w_mpos, w_spos;
    logic [CW-1:0] w_tmaj, w_tmin, w_len, w_maj_len, w_min_len, w_cmaj;
    logic [2*CW-1:0] w_prod;
    logic          w_last_line, w_pos_last, w_line_end;
    logic [RW-1:0] w_cnt;

    assign o_in_ready = (r_state == tlr_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_n_sat    = (i_tile_count > tlr_pkg::MAX_COUNT) ? tlr_pkg::MAX_COUNT : i_tile_count;

    assign w_wide = (i_cfg.mode == tlr_pkg::MODE_WIDE);
    assign w_grid = (i_cfg.mode == tlr_pkg::MODE_GRID);
    assign w_col  = i_cfg.variant;

    // master/stack geometry
    assign w_total      = w_wide ? r_ah : r_aw;
    assign w_span       = w_wide ? r_aw : r_ah;
    assign w_base_main  = w_wide ? r_ay : r_ax;
    assign w_base_cross = w_wide ? r_ax : r_ay;
    assign w_prod       = {{CW{1'b0}}, w_total} * {{CW{1'b0}}, i_cfg.ratio};
    assign w_ssize      = w_total - r_msize;
    assign w_mpos       = i_cfg.variant ? (w_base_main + w_ssize) : w_base_main;
    assign w_spos       = i_cfg.variant ? w_base_main : (w_base_main + r_msize);

    // grid geometry
    assign w_tmaj      = w_col ? r_ah : r_aw;
    assign w_tmin      = w_col ? r_aw : r_ah;
    assign w_last_line = ({1'b0, r_line} == (r_lines - 1'b1));
    assign w_cnt       = w_last_line ? r_last_cnt : r_line_cells;
    assign w_cmaj      = w_last_line ? r_cmaj_last : r_cell;
    assign w_pos_last  = ({1'b0, r_pos} == (w_cnt - 1'b1));
    assign w_line_end  = ({1'b0, r_pos} == (r_line_cells - 1'b1));
    assign w_maj_len   = w_pos_last ? (w_tmaj - r_maj_off) : w_cmaj;
    assign w_min_len   = w_last_line ? (w_tmin - r_min_off) : r_line_pitch;

    assign w_last = (r_k == (r_n - 1'b1));
    assign w_len  = w_last ? (w_span - r_off) : r_cell;
    assign w_load = (r_state == tlr_pkg::ST_EMIT) && (!r_out_valid || i_out_ready);

    // rectangle of tile r_k
    always_comb begin
        if (w_grid) begin
            if (w_col) begin
                w_x = r_ax + r_min_off;
                w_y = r_ay + r_maj_off;
                w_w = w_min_len;
                w_h = w_maj_len;
            end else begin
                w_x = r_ax + r_maj_off;
                w_y = r_ay + r_min_off;
                w_w = w_maj_len;
                w_h = w_min_len;
            end
        end else if (r_k == '0) begin
            if (w_wide) begin
                w_x = w_base_cross;
                w_y = w_mpos;
                w_w = w_span;
                w_h = r_msize;
            end else begin
                w_x = w_mpos;
                w_y = w_base_cross;
                w_w = r_msize;
                w_h = w_span;
            end
        end else begin
            if (w_wide) begin
                w_x = w_base_cross + r_off;
                w_y = w_spos;
                w_w = w_len;
                w_h = w_ssize;
            end else begin
                w_x = w_spos;
                w_y = w_base_cross + r_off;
                w_w = w_ssize;
                w_h = w_len;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_div_wait   = r_div_wait;
        n_msize      = r_msize;
        n_cell       = r_cell;
        n_lines      = r_lines;
        n_last_cnt   = r_last_cnt;
        n_line_pitch = r_line_pitch;
        n_cmaj_last  = r_cmaj_last;
        n_k          = r_k;
        n_off        = r_off;
        n_pos        = r_pos;
        n_line       = r_line;
        n_maj_off    = r_maj_off;
        n_min_off    = r_min_off;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = '0;

        case (r_state)
            tlr_pkg::ST_IDLE: begin
                n_k       = '0;
                n_off     = '0;
                n_pos     = '0;
                n_line    = '0;
                n_maj_off = '0;
                n_min_off = '0;
                if (w_accept && (w_n_sat != '0) && (i_cfg.mode != tlr_pkg::MODE_NONE)) begin
                    n_state = w_grid ? tlr_pkg::ST_DIV_LINES : tlr_pkg::ST_MUL;
                end
            end
            tlr_pkg::ST_MUL: begin
                n_msize = (r_n == NW'(1)) ? w_total : w_prod[2*CW-1:CW];
                n_state = (r_n == NW'(1)) ? tlr_pkg::ST_EMIT : tlr_pkg::ST_DIV_CELL;
            end
            tlr_pkg::ST_DIV_CELL, tlr_pkg::ST_DIV_LINES, tlr_pkg::ST_DIV_MINOR,
            tlr_pkg::ST_DIV_FULL, tlr_pkg::ST_DIV_LAST: begin
                case (r_state)
                    tlr_pkg::ST_DIV_CELL: begin
                        o_div_req.dividend = w_span;
                        o_div_req.divisor  = r_n - 1'b1;
                    end
                    tlr_pkg::ST_DIV_LINES: begin
                        // n - 1 = (lines - 1) * cells per line + (last_count - 1)
                        o_div_req.dividend = CW'(r_n - 1'b1);
                        o_div_req.divisor  = NW'(r_line_cells);
                    end
                    tlr_pkg::ST_DIV_MINOR: begin
                        o_div_req.dividend = w_tmin;
                        o_div_req.divisor  = NW'(r_lines);
                    end
                    tlr_pkg::ST_DIV_FULL: begin
                        o_div_req.dividend = w_tmaj;
                        o_div_req.divisor  = NW'(r_line_cells);
                    end
                    default: begin
                        o_div_req.dividend = w_tmaj;
                        o_div_req.divisor  = NW'(r_last_cnt);
                    end
                endcase
                if (!r_div_wait) begin
                    o_div_req.start = 1'b1;
                    n_div_wait      = 1'b1;
                end else if (i_div_rsp.done) begin
                    n_div_wait = 1'b0;
                    case (r_state)
                        tlr_pkg::ST_DIV_CELL: begin
                            n_cell  = i_div_rsp.quot;
                            n_state = tlr_pkg::ST_EMIT;
                        end
                        tlr_pkg::ST_DIV_LINES: begin
                            n_lines    = {1'b0, i_div_rsp.quot[LW-1:0]} + 1'b1;
                            n_last_cnt = {1'b0, i_div_rsp.rem[LW-1:0]} + 1'b1;
                            n_state    = tlr_pkg::ST_DIV_MINOR;
                        end
                        tlr_pkg::ST_DIV_MINOR: begin
                            n_line_pitch = i_div_rsp.quot;
                            n_state      = tlr_pkg::ST_DIV_FULL;
                        end
                        tlr_pkg::ST_DIV_FULL: begin
                            n_cell  = i_div_rsp.quot;
                            n_state = tlr_pkg::ST_DIV_LAST;
                        end
                        default: begin
                            n_cmaj_last = i_div_rsp.quot;
                            n_state     = tlr_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            tlr_pkg::ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_k         = r_k + 1'b1;
                    if (w_grid) begin
                        if (w_line_end) begin
                            n_pos     = '0;
                            n_maj_off = '0;
                            n_line    = r_line + 1'b1;
                            n_min_off = r_min_off + r_line_pitch;
                        end else begin
                            n_pos     = r_pos + 1'b1;
                            n_maj_off = r_maj_off + w_cmaj;
                        end
                    end else if (r_k != '0) begin
                        n_off = r_off + r_cell;
                    end
                    if (w_last) begin
                        n_state = tlr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlr_pkg::ST_IDLE;
            r_div_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_wait  <= n_div_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax         <= i_area_x;
            r_ay         <= i_area_y;
            r_aw         <= i_area_width;
            r_ah         <= i_area_height;
            r_n          <= w_n_sat;
            r_line_cells <= tlr_pkg::f_ceil_root(w_n_sat);
        end
        r_msize      <= n_msize;
        r_cell       <= n_cell;
        r_lines      <= n_lines;
        r_last_cnt   <= n_last_cnt;
        r_line_pitch <= n_line_pitch;
        r_cmaj_last  <= n_cmaj_last;
        r_k          <= n_k;
        r_off        <= n_off;
        r_pos        <= n_pos;
        r_line       <= n_line;
        r_maj_off    <= n_maj_off;
        r_min_off    <= n_min_off;
        if (w_load) begin
            r_o_k    <= r_k[tlr_pkg::INDEX_W-1:0];
            r_o_x    <= w_x;
            r_o_y    <= w_y;
            r_o_w    <= w_w;
            r_o_h    <= w_h;
            r_o_last <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tile_index  = r_o_k;
    assign o_tile_x      = r_o_x;
    assign o_tile_y      = r_o_y;
    assign o_tile_width  = r_o_w;
    assign o_tile_height = r_o_h;
    assign o_last_tile   = r_o_last;

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlr_pkg::ST_EMIT) |-> (r_k < r_n))
        else $error("tile counter past tile count");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == tlr_pkg::ST_IDLE))
        else $error("walk did not end after last tile");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divider started while busy");

    a_grid_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tlr_pkg::ST_EMIT) && w_grid) |-> ({1'b0, r_pos} < r_line_cells))
        else $error("grid position past line length");

endmodule

// ===== rtl/core/tile_layout_rect_generator_core.sv =====
// setup: tall/wide mode does the master multiply, then one division on the shared divider
//   (no division when n is 1); grid mode does four divisions on the shared divider
// output: then one tile per cycle while the output is taken; a new item is accepted only
//   after the last tile of the previous one is loaded, and an item with no tile, or in
//   mode 3, is taken with no output; the divider takes most of the setup
// reset: synchronous active low; layout_mode 0, variant 0, ratio 0x8000, no output
module tile_layout_rect_generator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tlr_pkg::COORD_W-1:0]   i_cfg_wdata,
    // area item
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_x,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_y,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_width,
    input  logic [tlr_pkg::COORD_W-1:0]   i_area_height,
    input  logic [tlr_pkg::COUNT_W-1:0]   i_tile_count,
    // tile items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tlr_pkg::INDEX_W-1:0]   o_tile_index,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_x,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_y,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_width,
    output logic [tlr_pkg::COORD_W-1:0]   o_tile_height,
    output logic                          o_last_tile
);

    // layout registers; the user must write them only while no item is in flight, the block does not enforce it
    logic [1:0]                  r_mode;
    logic                        r_variant;
    logic [tlr_pkg::COORD_W-1:0] r_ratio;

    tlr_pkg::t_cfg     w_cfg;
    tlr_pkg::t_div_req w_div_req;
    tlr_pkg::t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tlr_pkg::MODE_TALL;
            r_variant <= 1'b0;
            r_ratio   <= tlr_pkg::RATIO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlr_pkg::CFG_MODE:    r_mode    <= i_cfg_wdata[1:0];
                tlr_pkg::CFG_VARIANT: r_variant <= i_cfg_wdata[0];
                tlr_pkg::CFG_RATIO:   r_ratio   <= i_cfg_wdata;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign w_cfg.mode    = r_mode;
    assign w_cfg.variant = r_variant;
    assign w_cfg.ratio   = r_ratio;

    // sequencer: master multiply in tall/wide mode, then divisions on the shared unit, then the tile walk
    // with running offsets (no per-tile multiply) into a one-entry output register
    tlr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_area_x      (i_area_x),
        .i_area_y      (i_area_y),
        .i_area_width  (i_area_width),
        .i_area_height (i_area_height),
        .i_tile_count  (i_tile_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tile_index  (o_tile_index),
        .o_tile_x      (o_tile_x),
        .o_tile_y      (o_tile_y),
        .o_tile_width  (o_tile_width),
        .o_tile_height (o_tile_height),
        .o_last_tile   (o_last_tile),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp)
    );

    // shared 16-bit by 7-bit restoring divider, one quotient bit per cycle
    tlr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule
